// File: rtl/mtmq_pkg.sv
// mtmq_pkg: shared types and constants of the message tag match queue
// holds field widths, operation codes, the stored entry layout and default sizes
// no dependencies
package mtmq_pkg;

	// default sizes for the top-level parameters
	localparam int DEF_NUM_RANKS   = 16;
	localparam int DEF_QUEUE_DEPTH = 16;

	// fixed field widths of the item interfaces
	localparam int OP_W     = 2;
	localparam int RANK_W   = 4;
	localparam int TAG_W    = 15;
	localparam int LEN_W    = 16;
	localparam int HANDLE_W = 32;

	// operation codes
	localparam logic [OP_W-1:0] OP_SEND  = 2'd0;
	localparam logic [OP_W-1:0] OP_PROBE = 2'd1;
	localparam logic [OP_W-1:0] OP_RECV  = 2'd2;

	// one stored message descriptor
	typedef struct packed {
		logic [RANK_W-1:0]   src;
		logic [TAG_W-1:0]    tag;
		logic [LEN_W-1:0]    len;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/mtmq_ram.sv
// mtmq_ram: generic single-write, single-read memory with registered read data
// used for the descriptor store and the per-queue fill counts
// no dependencies
module mtmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/message_tag_match_queue.sv
// message_tag_match_queue: per-rank ordered message queues with source/tag matching
// Depends on mtmq_pkg and mtmq_ram.
//
// Usage: items enter on in_valid/in_stall carrying operation, ranks, tag, wildcards,
// length and handle. One result item leaves per input item on out_valid/out_stall.
// A send appends a descriptor to the destination queue or reports send_dropped when
// that queue is full or the rank does not exist. A probe scans the owner's queue
// oldest first and reports the first match; a receive also removes the matched
// entry, moving later entries down one slot, and returns copy_bytes.
// Timing: one item at a time; in_stall is high from acceptance until the result is
// loaded into the output register. A send appends in the fill state and goes straight
// to the result. A probe or receive scans the queue oldest first until an entry
// matches or the queue ends; a receive then moves the later entries down. Their
// pace is set by the single read port of the descriptor memory, which the scan and
// the compaction both walk one entry a cycle.
// The output register holds a finished result while out_stall is high; the block
// can accept the next item meanwhile, but finishes it only once that result leaves.
// Reset clears all queues at once (per-rank valid bits on the fill counts) and
// empties the output register; no clearing pass is needed.
module message_tag_match_queue
	import mtmq_pkg::*;
#(
	parameter int NUM_RANKS   = DEF_NUM_RANKS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic [RANK_W-1:0]   own_rank,
	input  logic [RANK_W-1:0]   dest_rank,
	input  logic [RANK_W-1:0]   want_source,
	input  logic                src_wildcard,
	input  logic [TAG_W-1:0]    tag,
	input  logic                any_tag,
	input  logic [LEN_W-1:0]    payload_length,
	input  logic [HANDLE_W-1:0] payload_handle,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                found,
	output logic                send_dropped,
	output logic [RANK_W-1:0]   msg_source,
	output logic [TAG_W-1:0]    msg_tag,
	output logic [LEN_W-1:0]    msg_length,
	output logic [HANDLE_W-1:0] msg_handle,
	output logic [LEN_W-1:0]    copy_bytes
);

	// derived widths
	localparam int RW  = $clog2(NUM_RANKS);
	localparam int RXW = (RW > RANK_W) ? RW : RANK_W;
	localparam int SW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW  = $clog2(QUEUE_DEPTH + 1);
	localparam int AW  = RW + SW;
	localparam int ENTRY_DEPTH = NUM_RANKS * (2 ** SW);
	localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_FILL   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_SHIFT  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// latched item
	logic [OP_W-1:0]     op_q;
	logic [RANK_W-1:0]   rank_q;
	logic [RANK_W-1:0]   src_q;
	logic [RANK_W-1:0]   want_src_q;
	logic                any_src_q;
	logic [TAG_W-1:0]    tag_q;
	logic                any_tag_q;
	logic [LEN_W-1:0]    len_q;
	logic [HANDLE_W-1:0] handle_q;

	// scan and compaction pointers
	logic [FW-1:0] n_q;
	logic [FW-1:0] idx_q;
	logic          pend_q;
	logic [FW-1:0] pend_idx_q;

	// staged result
	logic                res_found_q;
	logic                res_drop_q;
	logic [RANK_W-1:0]   res_src_q;
	logic [TAG_W-1:0]    res_tag_q;
	logic [LEN_W-1:0]    res_len_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic [LEN_W-1:0]    res_copy_q;

	// output register
	logic                out_valid_q;
	logic                out_found_q;
	logic                out_drop_q;
	logic [RANK_W-1:0]   out_src_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [LEN_W-1:0]    out_len_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [LEN_W-1:0]    out_copy_q;

	// per-rank valid bits of the fill counts
	logic [NUM_RANKS-1:0] fvalid_q;

	// memory ports
	logic          f_rd_en, f_wr_en;
	logic [RW-1:0] f_rd_addr;
	logic [FW-1:0] f_rd_data, f_wr_data;
	logic          e_rd_en, e_wr_en;
	logic [AW-1:0] e_rd_addr, e_wr_addr;
	entry_t        e_rd_data, e_wr_data;

	// decode helpers
	logic [RANK_W-1:0] sel_rank;
	logic [RXW-1:0]    sel_ext, rank_ext;
	logic [RW-1:0]     rank_idx;
	logic              rank_ok;
	logic [FW-1:0]     fill_cur;
	logic              send_ok;
	logic              more_rd;
	logic              hit;
	logic [FW-1:0]     pend_prev;
	logic              out_free;
	logic [LEN_W-1:0]  copy_min;

	assign sel_rank  = (operation == OP_SEND) ? dest_rank : own_rank;
	assign sel_ext   = RXW'(sel_rank);
	assign f_rd_addr = sel_ext[RW-1:0];
	assign f_rd_en   = (state_q == ST_IDLE) && in_valid;

	assign rank_ext = RXW'(rank_q);
	assign rank_idx = rank_ext[RW-1:0];
	assign rank_ok  = 32'(rank_q) < NUM_RANKS;

	// fill count of the selected queue, zero until first written
	assign fill_cur = fvalid_q[rank_idx] ? f_rd_data : '0;
	assign send_ok  = rank_ok && (fill_cur < DEPTH_F);

	assign more_rd   = idx_q < n_q;
	assign pend_prev = pend_idx_q - FW'(1);

	// match test on the entry read in the previous cycle
	assign hit = pend_q
		&& (any_src_q || (e_rd_data.src == want_src_q))
		&& (any_tag_q || (e_rd_data.tag == tag_q));

	assign copy_min = (len_q < e_rd_data.len) ? len_q : e_rd_data.len;
	assign out_free = !out_valid_q || !out_stall;

	// descriptor memory read: one entry a cycle during scan and compaction
	assign e_rd_en   = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && more_rd;
	assign e_rd_addr = {rank_idx, idx_q[SW-1:0]};

	// descriptor memory write: append on send, move down during compaction
	always_comb begin
		e_wr_en   = 1'b0;
		e_wr_addr = {rank_idx, pend_prev[SW-1:0]};
		e_wr_data = e_rd_data;
		if (state_q == ST_FILL) begin
			e_wr_en          = (op_q == OP_SEND) && send_ok;
			e_wr_addr        = {rank_idx, fill_cur[SW-1:0]};
			e_wr_data.src    = src_q;
			e_wr_data.tag    = tag_q;
			e_wr_data.len    = len_q;
			e_wr_data.handle = handle_q;
		end else if (state_q == ST_SHIFT) begin
			e_wr_en = pend_q;
		end
	end

	// fill count write: grow on send, shrink on receive match
	always_comb begin
		f_wr_en   = 1'b0;
		f_wr_data = n_q - FW'(1);
		if (state_q == ST_FILL) begin
			f_wr_en   = (op_q == OP_SEND) && send_ok;
			f_wr_data = fill_cur + FW'(1);
		end else if (state_q == ST_SCAN) begin
			f_wr_en = hit && (op_q == OP_RECV);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (((op_q == OP_PROBE) || (op_q == OP_RECV)) && rank_ok
						&& (fill_cur != '0)) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = (op_q == OP_RECV) ? ST_SHIFT : ST_RESULT;
				end else if (pend_q && !more_rd) begin
					state_d = ST_RESULT;
				end
			end
			ST_SHIFT: begin
				if (!more_rd) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			fvalid_q    <= '0;
			pend_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (f_wr_en) begin
				fvalid_q[rank_idx] <= 1'b1;
			end
			if ((state_q == ST_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_SCAN: begin
					pend_q <= hit ? 1'b0 : more_rd;
				end
				ST_SHIFT: begin
					pend_q <= more_rd;
				end
				default: pend_q <= 1'b0;
			endcase
		end
	end

	// item, pointer and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q       <= operation;
				rank_q     <= sel_rank;
				src_q      <= own_rank;
				want_src_q <= want_source;
				any_src_q  <= src_wildcard;
				tag_q      <= tag;
				any_tag_q  <= any_tag;
				len_q      <= payload_length;
				handle_q   <= payload_handle;
			end
			ST_FILL: begin
				n_q          <= fill_cur;
				idx_q        <= '0;
				res_found_q  <= 1'b0;
				res_drop_q   <= (op_q == OP_SEND) && !send_ok;
				res_src_q    <= '0;
				res_tag_q    <= '0;
				res_len_q    <= '0;
				res_handle_q <= '0;
				res_copy_q   <= '0;
			end
			ST_SCAN: begin
				if (hit) begin
					res_found_q  <= 1'b1;
					res_src_q    <= e_rd_data.src;
					res_tag_q    <= e_rd_data.tag;
					res_len_q    <= e_rd_data.len;
					res_handle_q <= e_rd_data.handle;
					res_copy_q   <= (op_q == OP_RECV) ? copy_min : '0;
					idx_q        <= pend_idx_q + FW'(1);
				end else if (more_rd) begin
					idx_q      <= idx_q + FW'(1);
					pend_idx_q <= idx_q;
				end
			end
			ST_SHIFT: begin
				if (more_rd) begin
					idx_q      <= idx_q + FW'(1);
					pend_idx_q <= idx_q;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					out_found_q  <= res_found_q;
					out_drop_q   <= res_drop_q;
					out_src_q    <= res_src_q;
					out_tag_q    <= res_tag_q;
					out_len_q    <= res_len_q;
					out_handle_q <= res_handle_q;
					out_copy_q   <= res_copy_q;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// per-rank fill counts
	mtmq_ram #(
		.WIDTH(FW),
		.DEPTH(NUM_RANKS)
	) u_fill_ram (
		.clk    (clk),
		.wr_en  (f_wr_en),
		.wr_addr(rank_idx),
		.wr_data(f_wr_data),
		.rd_en  (f_rd_en),
		.rd_addr(f_rd_addr),
		.rd_data(f_rd_data)
	);

	// message descriptors, one row of slots per rank
	mtmq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRY_DEPTH)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (e_wr_en),
		.wr_addr(e_wr_addr),
		.wr_data(e_wr_data),
		.rd_en  (e_rd_en),
		.rd_addr(e_rd_addr),
		.rd_data(e_rd_data)
	);

	// ports
	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign found        = out_found_q;
	assign send_dropped = out_drop_q;
	assign msg_source   = out_src_q;
	assign msg_tag      = out_tag_q;
	assign msg_length   = out_len_q;
	assign msg_handle   = out_handle_q;
	assign copy_bytes   = out_copy_q;

endmodule
